/* rtl/asfs_pkg.sv */
package asfs_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int ANGLE_W     = 16;
   localparam int FRAME_W     = 8;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic [ANGLE_W-1:0] HALF_TURN = {1'b1, {(ANGLE_W-1){1'b0}}};

   // request codes
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_UPDATE = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_NEWREV = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [ANGLE_W-1:0] angle;
      logic [FRAME_W-1:0] frame_id;
   } asfs_req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] primary_id;
      logic [FRAME_W-1:0] follower_id;
      logic               primary_changed;
      logic               follower_changed;
      logic               selection_valid;
      logic               lookup_found;
      logic [FRAME_W-1:0] lookup_id;
      logic               table_full;
   } asfs_rsp_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } asfs_cmd_type;

   typedef struct packed {
      logic empty;
      logic walk_last;
      logic out_free;
   } asfs_stat_type;

endpackage

/* rtl/asfs_ctrl.sv */
module asfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  asfs_pkg::asfs_stat_type stat,
   output asfs_pkg::asfs_cmd_type  cmd
);
   import asfs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = stat.empty ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.walk_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/asfs_dp.sv */
module asfs_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  asfs_pkg::asfs_req_type  req_data,
   input  asfs_pkg::asfs_cmd_type  cmd,
   output asfs_pkg::asfs_stat_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output asfs_pkg::asfs_rsp_type  rsp_data
);
   import asfs_pkg::*;

   // sorted table
   logic [ANGLE_W-1:0] ang_ff [MAX_ENTRIES];
   logic [ANGLE_W-1:0] ang_in [MAX_ENTRIES];
   logic [FRAME_W-1:0] frm_ff [MAX_ENTRIES];
   logic [FRAME_W-1:0] frm_in [MAX_ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;

   // selections, with the frame id captured when selected
   logic               pv_ff, pv_in, fv_ff, fv_in;
   logic [IDX_W-1:0]   pslot_ff, pslot_in, fslot_ff, fslot_in;
   logic [FRAME_W-1:0] pframe_ff, pframe_in, fframe_ff, fframe_in;

   // walk state
   asfs_req_type       req_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               ph_ff, fh_ff, lh_ff;
   logic [IDX_W-1:0]   ps_ff, fs_ff;
   logic [FRAME_W-1:0] pf_ff, ff_ff, lf_ff, last_ff;
   logic [CNT_W-1:0]   pos_ff;

   logic               rsp_valid_ff;
   asfs_rsp_type       rsp_ff, rsp_in;

   logic [ANGLE_W-1:0] fol_angle;
   logic [ANGLE_W-1:0] cur_ang;
   logic [FRAME_W-1:0] cur_frm;
   logic [IDX_W-1:0]   top_slot;
   logic [IDX_W-1:0]   p_new, f_new;
   logic [FRAME_W-1:0] pf_new, ff_new;

   assign fol_angle = req_ff.angle + HALF_TURN;
   assign cur_ang   = ang_ff[idx_ff];
   assign cur_frm   = frm_ff[idx_ff];
   assign top_slot  = IDX_W'(count_ff - CNT_W'(1));

   assign stat.empty     = (count_ff == '0);
   assign stat.walk_last = ({1'b0, idx_ff} == CNT_W'(count_ff - CNT_W'(1)));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // no entry low enough: wrap to the last slot
   assign p_new  = ph_ff ? ps_ff : top_slot;
   assign f_new  = fh_ff ? fs_ff : top_slot;
   assign pf_new = ph_ff ? pf_ff : last_ff;
   assign ff_new = fh_ff ? ff_ff : last_ff;

   always_comb begin
      ang_in    = ang_ff;
      frm_in    = frm_ff;
      count_in  = count_ff;
      pv_in     = pv_ff;
      fv_in     = fv_ff;
      pslot_in  = pslot_ff;
      fslot_in  = fslot_ff;
      pframe_in = pframe_ff;
      fframe_in = fframe_ff;
      rsp_in    = '0;
      if (cmd.finish) begin
         unique case (req_ff.req_type)
            REQ_ADD: begin
               if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  rsp_in.table_full = 1'b1;
               end else begin
                  // shift the tail up one slot and drop the new pair in
                  for (int k = 0; k < MAX_ENTRIES; k++) begin
                     if (CNT_W'(k) > pos_ff && k > 0) begin
                        ang_in[k] = ang_ff[k-1];
                        frm_in[k] = frm_ff[k-1];
                     end else if (CNT_W'(k) == pos_ff) begin
                        ang_in[k] = req_ff.angle;
                        frm_in[k] = req_ff.frame_id;
                     end
                  end
                  count_in = count_ff + CNT_W'(1);
                  pv_in    = 1'b0;
                  fv_in    = 1'b0;
               end
            end
            REQ_UPDATE: begin
               if (count_ff != '0) begin
                  rsp_in.primary_changed  = !pv_ff || (pslot_ff != p_new);
                  rsp_in.follower_changed = !fv_ff || (fslot_ff != f_new);
                  pslot_in  = p_new;
                  fslot_in  = f_new;
                  pframe_in = pf_new;
                  fframe_in = ff_new;
                  pv_in     = 1'b1;
                  fv_in     = 1'b1;
               end
            end
            REQ_LOOKUP: begin
               rsp_in.lookup_found = lh_ff;
               rsp_in.lookup_id    = lh_ff ? lf_ff : '0;
            end
            REQ_NEWREV: begin
               pv_in = 1'b0;
               fv_in = 1'b0;
            end
            default: ;
         endcase
         rsp_in.primary_id      = pv_in ? pframe_in : '0;
         rsp_in.follower_id     = fv_in ? fframe_in : '0;
         rsp_in.selection_valid = pv_in && fv_in && (count_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         fv_ff        <= 1'b0;
         pslot_ff     <= '0;
         fslot_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pv_ff    <= pv_in;
         fv_ff    <= fv_in;
         pslot_ff <= pslot_in;
         fslot_ff <= fslot_in;
         if (cmd.finish)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff    <= ang_in;
      frm_ff    <= frm_in;
      pframe_ff <= pframe_in;
      fframe_ff <= fframe_in;
      if (cmd.finish) rsp_ff <= rsp_in;
      if (cmd.start) begin
         req_ff <= req_data;
         idx_ff <= '0;
         ph_ff  <= 1'b0;
         fh_ff  <= 1'b0;
         lh_ff  <= 1'b0;
         pos_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (cur_ang <= req_ff.angle) begin
            ph_ff  <= 1'b1;
            ps_ff  <= idx_ff;
            pf_ff  <= cur_frm;
            pos_ff <= CNT_W'(idx_ff) + CNT_W'(1);
         end
         if (cur_ang <= fol_angle) begin
            fh_ff <= 1'b1;
            fs_ff <= idx_ff;
            ff_ff <= cur_frm;
         end
         if (!lh_ff && cur_ang == req_ff.angle) begin
            lh_ff <= 1'b1;
            lf_ff <= cur_frm;
         end
         if (stat.walk_last) last_ff <= cur_frm;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/angular_sector_frame_selector.sv */
// Angular sector frame selector.
// Holds up to MAX_ENTRIES (angle, frame id) pairs sorted by angle, angles being
// unsigned fractions of a turn. Requests arrive on the req_ channel as one
// packed transfer (type, angle, frame id); each gives exactly one transfer on
// the rsp_ channel. Add inserts a pair after any equal angles and clears the
// selections; angle update picks the primary sector (last entry not above
// the angle, else the top entry) and the follower at angle plus half a turn;
// lookup returns the first exact match; new revolution clears the selections.
// Sequence: the accepting cycle, then a walk over the stored entries (one
// compare set per entry, skipped when the table is empty), then a commit;
// the result is registered at the commit and then offered on rsp_.
// A new request is accepted the cycle after the commit; none is taken while
// a request is being walked or committed.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is accepted and walked, and the commit waits until
// the register frees up. Reset empties the table and drops both selections;
// the stored angles and ids themselves are not cleared.
module angular_sector_frame_selector (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  asfs_pkg::asfs_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output asfs_pkg::asfs_rsp_type rsp_data
);
   import asfs_pkg::*;

   asfs_cmd_type  cmd;
   asfs_stat_type stat;

   // sequence the walk and commit
   asfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, selection state and output register
   asfs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
